>>> hdl/rgb_linear_fade_engine_assert.svh
// Assertion macros for the RGB fade engine.
// Included by modules that carry concurrent checks; needs no package.
`ifndef RGB_LINEAR_FADE_ENGINE_ASSERT_SVH
`define RGB_LINEAR_FADE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RLFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlfe: same-cycle check failed");
// next-cycle implication
`define RLFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlfe: next-cycle check failed");
`else
`define RLFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RLFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/rlfe_pkg.sv
// Shared types and constants for the RGB fade engine.
// No dependencies.
package rlfe_pkg;

    localparam int CHAN_BITS = 8;
    localparam int DIV_STEPS = CHAN_BITS;
    localparam int STEP_BITS = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_SET  = 2'd1,
        MODE_FADE = 2'd2,
        MODE_OFF  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } t_rgb;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 capture;
        logic                 exec;
        logic                 check;
        logic                 mul;
        logic                 load;
        logic                 step;
        logic [STEP_BITS-1:0] k;
        logic                 wb;
        logic                 emit;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  fading;
        logic  reached;
        logic  out_free;
    } t_sts;

endpackage

>>> hdl/rlfe_ifs.sv
// Valid/ready channel interfaces for the RGB fade engine: input items and results.
// No dependencies.
interface rlfe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [31:0] fade_time;

    modport source (output valid, mode, red_in, green_in, blue_in, fade_time, input ready);
    modport sink   (input valid, mode, red_in, green_in, blue_in, fade_time, output ready);
endinterface

interface rlfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       fade_active;
    logic       refreshed;

    modport source (output valid, red_out, green_out, blue_out, fade_active, refreshed,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, fade_active, refreshed,
                    output ready);
endinterface

>>> hdl/rgb_linear_fade_engine.sv
// RGB linear fade engine: one item at a time, through EXEC and DONE for set, fade, off and
// idle ticks, also CHECK for a tick that ends a fade, and CHECK, MUL, LOAD, DIV and WB for an
// interpolating tick (one 8xTIME_BITS multiply and an 8-step restoring divide per channel).
// DONE holds until the result register is free; a new item is taken the cycle after it loads.
// Synchronous active-low reset: black shown, no fade, no result pending.
// Depends on rlfe_pkg, rlfe_ifs, rlfe_ctrl, rlfe_dp.
module rgb_linear_fade_engine #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlfe_in_if.sink     i_item,
    rlfe_out_if.source  o_result
);

    rlfe_pkg::t_cmd cmd;
    rlfe_pkg::t_sts sts;
    logic           in_ready;

    assign i_item.ready = in_ready;

    rlfe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .o_ready (in_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rlfe_dp #(.TIME_BITS(TIME_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

>>> hdl/rlfe_lane.sv
// One color channel of the interpolator: 8xTIME_BITS multiply, then an
// 8-step restoring divide. Depends on rlfe_pkg.
module rlfe_lane #(
    parameter int TIME_BITS = 32
) (
    input  logic                               i_clk,
    input  rlfe_pkg::t_cmd                     i_cmd,
    input  logic [rlfe_pkg::CHAN_BITS-1:0]     i_start,
    input  logic [rlfe_pkg::CHAN_BITS-1:0]     i_target,
    input  logic [TIME_BITS-1:0]               i_num,
    input  logic [TIME_BITS-1:0]               i_den,
    output logic [rlfe_pkg::CHAN_BITS-1:0]     o_chan
);

    localparam int W = rlfe_pkg::CHAN_BITS + TIME_BITS;

    logic                           r_dec;
    logic [rlfe_pkg::CHAN_BITS-1:0] r_q;
    logic [W-1:0]                   r_prod;
    logic [W-1:0]                   r_rem;
    logic [rlfe_pkg::CHAN_BITS-1:0] diff;
    logic [W-1:0]                   trial;
    logic [W-1:0]                   corr;

    assign diff  = (i_target < i_start) ? (i_start - i_target) : (i_target - i_start);
    assign trial = W'(i_den) << i_cmd.k;
    assign corr  = r_dec ? (W'(i_den) - W'(1)) : '0;

    // descending channel rounds the quotient up
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dec  <= (i_target < i_start);
            r_prod <= W'(diff) * W'(i_num);
        end
        if (i_cmd.load) begin
            r_rem <= r_prod + corr;
            r_q   <= '0;
        end else if (i_cmd.step) begin
            if (r_rem >= trial) begin
                r_rem        <= r_rem - trial;
                r_q[i_cmd.k] <= 1'b1;
            end
        end
    end

    assign o_chan = r_dec ? (i_start - r_q) : (i_start + r_q);

endmodule

>>> hdl/rlfe_dp.sv
// Datapath of the RGB fade engine: fade state, item capture, three lanes
// and the result register. Depends on rlfe_pkg, rlfe_ifs and rlfe_lane.
module rlfe_dp #(
    parameter int TIME_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rlfe_pkg::t_cmd     i_cmd,
    output rlfe_pkg::t_sts     o_sts,
    rlfe_in_if.sink            i_item,
    rlfe_out_if.source         o_result
);

    localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);

    rlfe_pkg::t_mode        r_mode;
    rlfe_pkg::t_rgb         r_color;
    logic [31:0]            r_ft;

    rlfe_pkg::t_rgb         r_shown;
    rlfe_pkg::t_rgb         r_start;
    rlfe_pkg::t_rgb         r_target;
    logic [TIME_BITS-1:0]   r_elapsed;
    logic [TIME_BITS-1:0]   r_len;
    logic                   r_fade_on;
    logic                   r_refr;

    logic                   r_out_valid;
    rlfe_pkg::t_rgb         r_out_rgb;
    logic                   r_out_fade;
    logic                   r_out_refr;

    logic [TIME_BITS-1:0]   len_sat;
    logic [TIME_BITS-1:0]   elapsed_inc;
    rlfe_pkg::t_rgb         lerp;

    assign len_sat     = (r_ft > TIME_MAX32) ? TIME_MAX32[TIME_BITS-1:0]
                                             : r_ft[TIME_BITS-1:0];
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TIME_BITS'(1);

    rlfe_lane #(.TIME_BITS(TIME_BITS)) u_lane_r (
        .i_clk(i_clk), .i_cmd(i_cmd), .i_start(r_start.red), .i_target(r_target.red),
        .i_num(r_elapsed), .i_den(r_len), .o_chan(lerp.red)
    );
    rlfe_lane #(.TIME_BITS(TIME_BITS)) u_lane_g (
        .i_clk(i_clk), .i_cmd(i_cmd), .i_start(r_start.green), .i_target(r_target.green),
        .i_num(r_elapsed), .i_den(r_len), .o_chan(lerp.green)
    );
    rlfe_lane #(.TIME_BITS(TIME_BITS)) u_lane_b (
        .i_clk(i_clk), .i_cmd(i_cmd), .i_start(r_start.blue), .i_target(r_target.blue),
        .i_num(r_elapsed), .i_den(r_len), .o_chan(lerp.blue)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= rlfe_pkg::t_mode'(i_item.mode);
            r_color <= '{red: i_item.red_in, green: i_item.green_in, blue: i_item.blue_in};
            r_ft    <= i_item.fade_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown   <= '0;
            r_start   <= '0;
            r_target  <= '0;
            r_elapsed <= '0;
            r_len     <= '0;
            r_fade_on <= 1'b0;
            r_refr    <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                case (r_mode)
                    rlfe_pkg::MODE_TICK: begin
                        if (r_fade_on) r_elapsed <= elapsed_inc;
                        r_refr <= r_fade_on;
                    end
                    rlfe_pkg::MODE_SET: begin
                        r_shown <= r_color;
                        r_refr  <= 1'b1;
                    end
                    rlfe_pkg::MODE_FADE: begin
                        r_start   <= r_shown;
                        r_target  <= r_color;
                        r_elapsed <= '0;
                        r_len     <= len_sat;
                        r_fade_on <= 1'b1;
                        r_refr    <= 1'b0;
                    end
                    rlfe_pkg::MODE_OFF: begin
                        r_shown   <= '0;
                        r_fade_on <= 1'b0;
                        r_refr    <= 1'b1;
                    end
                    default: r_refr <= 1'b0;
                endcase
            end
            if (i_cmd.check && (r_elapsed >= r_len)) begin
                r_shown   <= r_target;
                r_fade_on <= 1'b0;
            end
            if (i_cmd.wb) r_shown <= lerp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_rgb  <= r_shown;
            r_out_fade <= r_fade_on;
            r_out_refr <= r_refr;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.red_out     = r_out_rgb.red;
    assign o_result.green_out   = r_out_rgb.green;
    assign o_result.blue_out    = r_out_rgb.blue;
    assign o_result.fade_active = r_out_fade;
    assign o_result.refreshed   = r_out_refr;

    assign o_sts.mode     = r_mode;
    assign o_sts.fading   = r_fade_on;
    assign o_sts.reached  = (r_elapsed >= r_len);
    assign o_sts.out_free = !r_out_valid || o_result.ready;

endmodule

>>> hdl/rlfe_ctrl.sv
// Controller of the RGB fade engine: sequences one item through the datapath.
// Depends on rlfe_pkg and rgb_linear_fade_engine_assert.svh.
`include "rgb_linear_fade_engine_assert.svh"

module rlfe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rlfe_pkg::t_sts i_sts,
    output rlfe_pkg::t_cmd o_cmd
);

    rlfe_pkg::t_state                 r_state;
    rlfe_pkg::t_state                 n_state;
    logic [rlfe_pkg::STEP_BITS-1:0]   r_cnt;
    logic [rlfe_pkg::STEP_BITS-1:0]   n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlfe_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            rlfe_pkg::S_IDLE:  if (i_valid) n_state = rlfe_pkg::S_EXEC;
            rlfe_pkg::S_EXEC: begin
                if (i_sts.mode == rlfe_pkg::MODE_TICK && i_sts.fading)
                    n_state = rlfe_pkg::S_CHECK;
                else
                    n_state = rlfe_pkg::S_DONE;
            end
            rlfe_pkg::S_CHECK: n_state = i_sts.reached ? rlfe_pkg::S_DONE : rlfe_pkg::S_MUL;
            rlfe_pkg::S_MUL:   n_state = rlfe_pkg::S_LOAD;
            rlfe_pkg::S_LOAD: begin
                n_state = rlfe_pkg::S_DIV;
                n_cnt   = rlfe_pkg::STEP_BITS'(rlfe_pkg::DIV_STEPS - 1);
            end
            rlfe_pkg::S_DIV: begin
                if (r_cnt == '0) n_state = rlfe_pkg::S_WB;
                else             n_cnt   = r_cnt - 1'b1;
            end
            rlfe_pkg::S_WB:    n_state = rlfe_pkg::S_DONE;
            rlfe_pkg::S_DONE:  if (i_sts.out_free) n_state = rlfe_pkg::S_IDLE;
            default:           n_state = rlfe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            rlfe_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.capture = i_valid;
            end
            rlfe_pkg::S_EXEC:  o_cmd.exec  = 1'b1;
            rlfe_pkg::S_CHECK: o_cmd.check = 1'b1;
            rlfe_pkg::S_MUL:   o_cmd.mul   = 1'b1;
            rlfe_pkg::S_LOAD:  o_cmd.load  = 1'b1;
            rlfe_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                o_cmd.k    = r_cnt;
            end
            rlfe_pkg::S_WB:    o_cmd.wb    = 1'b1;
            rlfe_pkg::S_DONE:  o_cmd.emit  = i_sts.out_free;
            default:           o_cmd       = '0;
        endcase
    end

    `RLFE_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, i_valid && o_ready, r_state == rlfe_pkg::S_EXEC)
    `RLFE_ASSERT_NXT(a_div_holds, i_clk, i_rst_n, r_state == rlfe_pkg::S_DIV && r_cnt != '0, r_state == rlfe_pkg::S_DIV)
    `RLFE_ASSERT_NXT(a_emit_idle, i_clk, i_rst_n, o_cmd.emit, r_state == rlfe_pkg::S_IDLE)
    `RLFE_ASSERT_IMP(a_check_tick, i_clk, i_rst_n, r_state == rlfe_pkg::S_CHECK, i_sts.mode == rlfe_pkg::MODE_TICK)

endmodule

>>> sim/rgb_linear_fade_engine_tb.sv
// Self-checking testbench for rgb_linear_fade_engine: directed and random beats
// with idle/stall phases, checked against an in-bench crossfade predictor.
// Depends on rlfe_pkg, rlfe_ifs and the engine RTL.
module rgb_linear_fade_engine_tb;

    localparam int TIME_BITS      = 32;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF       = 400;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 440;

    typedef struct packed {
        rlfe_pkg::t_rgb color;
        logic           active;
        logic           refreshed;
    } t_shown;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rlfe_in_if  item_if ();
    rlfe_out_if result_if ();

    rgb_linear_fade_engine #(.TIME_BITS(TIME_BITS)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    rlfe_pkg::t_rgb       disp_color;
    rlfe_pkg::t_rgb       fade_from;
    rlfe_pkg::t_rgb       fade_to;
    logic [TIME_BITS-1:0] ms_elapsed;
    logic [TIME_BITS-1:0] ms_length;
    logic                 fading;

    t_shown expected_shown[$];
    int     mismatches;
    int     items_done;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_request;
    int     quiet_cycles;

    function automatic logic [7:0] blend_chan(logic [7:0] s, logic [7:0] e,
                                              logic [63:0] num, logic [63:0] den);
        logic [63:0] d;
        logic [63:0] q;
        if (e >= s) begin
            d = e - s;
            q = (d * num) / den;
            return s + q[7:0];
        end
        d = s - e;
        q = (d * num + den - 1) / den;
        return s - q[7:0];
    endfunction

    function automatic t_shown next_shown(rlfe_pkg::t_mode m, rlfe_pkg::t_rgb c,
                                          logic [31:0] ft);
        logic [63:0] time_max;
        t_shown      res;
        time_max      = (64'd1 << TIME_BITS) - 1;
        res.refreshed = 1'b0;
        case (m)
            rlfe_pkg::MODE_TICK: begin
                if (fading) begin
                    if (64'(ms_elapsed) < time_max) ms_elapsed = ms_elapsed + 1'b1;
                    if (ms_elapsed >= ms_length) begin
                        disp_color = fade_to;
                        fading     = 1'b0;
                    end else begin
                        disp_color.red   = blend_chan(fade_from.red, fade_to.red,
                                                      ms_elapsed, ms_length);
                        disp_color.green = blend_chan(fade_from.green, fade_to.green,
                                                      ms_elapsed, ms_length);
                        disp_color.blue  = blend_chan(fade_from.blue, fade_to.blue,
                                                      ms_elapsed, ms_length);
                    end
                    res.refreshed = 1'b1;
                end
            end
            rlfe_pkg::MODE_SET: begin
                disp_color    = c;
                res.refreshed = 1'b1;
            end
            rlfe_pkg::MODE_FADE: begin
                fade_from  = disp_color;
                fade_to    = c;
                ms_elapsed = '0;
                ms_length  = (64'(ft) > time_max) ? time_max[TIME_BITS-1:0] : ft;
                fading     = 1'b1;
            end
            default: begin
                disp_color    = '0;
                fading        = 1'b0;
                res.refreshed = 1'b1;
            end
        endcase
        res.color  = disp_color;
        res.active = fading;
        return res;
    endfunction

    task automatic send_item(rlfe_pkg::t_mode m, rlfe_pkg::t_rgb c, logic [31:0] ft);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.mode      <= m;
        item_if.red_in    <= c.red;
        item_if.green_in  <= c.green;
        item_if.blue_in   <= c.blue;
        item_if.fade_time <= ft;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        if (m != rlfe_pkg::MODE_TICK || fading) items_done++;
        expected_shown.push_back(next_shown(m, c, ft));
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (expected_shown.size() != 0) @(posedge i_clk);
    endtask

    // result side: stalls and long hold-off
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                result_if.ready <= 1'b0;
                hold_request--;
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_shown got;
        t_shown want;
        if (i_rst_n === 1'b1) begin
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (result_if.valid && result_if.ready) begin
                got.color.red   = result_if.red_out;
                got.color.green = result_if.green_out;
                got.color.blue  = result_if.blue_out;
                got.active      = result_if.fade_active;
                got.refreshed   = result_if.refreshed;
                if (expected_shown.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: rgb=%h active=%b refreshed=%b",
                                 got.color, got.active, got.refreshed);
                end else begin
                    want = expected_shown.pop_front();
                    if (got.color.red !== want.color.red
                        || got.color.green !== want.color.green
                        || got.color.blue !== want.color.blue
                        || got.active !== want.active
                        || got.refreshed !== want.refreshed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp rgb=%h active=%b refreshed=%b, ",
                                      "got rgb=%h active=%b refreshed=%b"},
                                     want.color, want.active, want.refreshed,
                                     got.color, got.active, got.refreshed);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);          // tick while idle
        send_item(rlfe_pkg::MODE_SET,  24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(rlfe_pkg::MODE_SET,  24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_SET,  24'hAA55A5, 32'h5555_AAAA);
        send_item(rlfe_pkg::MODE_OFF,  24'hFFFFFF, 32'hFFFF_FFFF);
        send_item(rlfe_pkg::MODE_SET,  24'h1080F0, 32'd0);
        send_item(rlfe_pkg::MODE_FADE, 24'hF02010, 32'd4);          // up and down channels
        repeat (4) send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_TICK, 24'hFFFFFF, 32'd0);
        send_item(rlfe_pkg::MODE_FADE, 24'h00FF7F, 32'd0);          // zero duration
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_FADE, 24'hFF0000, 32'hFFFF_FFFF);  // longest duration
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_SET,  24'h123456, 32'd0);          // set during fade
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_OFF,  24'h000000, 32'd0);          // off during fade
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_FADE, 24'hFFFFFF, 32'd7);
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_FADE, 24'h000000, 32'd3);  // refade from mid-fade color
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        send_item(rlfe_pkg::MODE_FADE, 24'h55AA00, 32'h8000_0000);
        send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(rlfe_pkg::MODE_SET, 24'h00FF00, 32'd0);
        hold_request = HOLD_OFF;
        send_item(rlfe_pkg::MODE_FADE, 24'hFF00FF, 32'd12);
        repeat (14) send_item(rlfe_pkg::MODE_TICK, 24'h000000, 32'd0);
        wait_drain();
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int n);
        int             target;
        int             ticks;
        logic [31:0]    dur;
        int             pick;
        rlfe_pkg::t_rgb col;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_done + n;
        while (items_done < target) begin
            if ($urandom_range(99) < 80) begin
                pick = $urandom_range(99);
                if (pick < 70)      dur = $urandom_range(40);
                else if (pick < 90) dur = $urandom_range(3000, 41);
                else                dur = $urandom;
                col = 24'($urandom_range(24'hFFFFFF));
                send_item(rlfe_pkg::MODE_FADE, col, dur);
                ticks = (dur < 45) ? $urandom_range(dur + 3) : $urandom_range(60);
                repeat (ticks) begin
                    pick = $urandom_range(99);
                    col  = 24'($urandom_range(24'hFFFFFF));
                    if (pick < 5)      send_item(rlfe_pkg::MODE_SET, col, $urandom);
                    else if (pick < 8) send_item(rlfe_pkg::MODE_OFF, col, $urandom);
                    else               send_item(rlfe_pkg::MODE_TICK, col, $urandom);
                end
            end else begin
                send_item(rlfe_pkg::t_mode'(2'($urandom_range(3))),
                          24'($urandom_range(24'hFFFFFF)), $urandom);
            end
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.mode       = rlfe_pkg::MODE_TICK;
        item_if.red_in     = '0;
        item_if.green_in   = '0;
        item_if.blue_in    = '0;
        item_if.fade_time  = '0;
        disp_color         = '0;
        fade_from          = '0;
        fade_to            = '0;
        ms_elapsed         = '0;
        ms_length          = '0;
        fading             = 1'b0;
        mismatches         = 0;
        items_done         = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_request       = 0;
        quiet_cycles       = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random(0, 0, PHASE_ITEMS);
        test_random(85, 0, PHASE_ITEMS);
        test_random(0, 85, PHASE_ITEMS);
        test_random(18, 18, PHASE_ITEMS);

        while (expected_shown.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_shown.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
